// File: design/pbu_pkg.sv
// Package for the pixel blend unit: blend mode codes and the item structs.
// No dependencies; used by pixel_blend_unit_top.
`timescale 1ns / 1ps
`default_nettype none

package pbu_pkg;

   // Blend mode codes held in the mode register
   typedef enum logic [3:0] {
      MODE_MUL        = 4'd0,
      MODE_SUB        = 4'd1,
      MODE_MUL_SCREEN = 4'd2,
      MODE_MUL_SUB    = 4'd3,
      MODE_OVERLAY    = 4'd4,
      MODE_GREEN_ADD  = 4'd5,
      MODE_BLUE0_RED4 = 4'd6,
      MODE_COPY       = 4'd7,
      MODE_MERGE      = 4'd8
   } blend_mode_type;

   // Input item: one pixel from each of three images
   typedef struct packed {
      logic [7:0] a_blue;
      logic [7:0] a_green;
      logic [7:0] a_red;
      logic [7:0] b_blue;
      logic [7:0] b_green;
      logic [7:0] b_red;
      logic [7:0] c_blue;
      logic [7:0] c_green;
      logic [7:0] c_red;
   } req_type;

   // Result item: the blended pixel
   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
   } rsp_type;

   // Reciprocal of 255 scaled by 2^25; exact floor for dividends below 132626
   localparam logic [17:0] RECIP_255   = 18'd131587;
   localparam int          RECIP_SHIFT = 25;

endpackage

`default_nettype wire

// File: design/pixel_blend_unit_top.sv
// Pixel blend unit top level: five-stage pipeline blending three pixels per item.
// Depends on pbu_pkg (mode codes, item structs, reciprocal constant).
//
//   channel   ports                       handshake
//   input     req_data                    start high, busy low at the clock edge
//   result    rsp_data                    rsp_valid high for one cycle
//   config    csr_wr_data                 csr_wr_en high at the clock edge
//
// One item is taken every cycle; its result comes out of the last stage register in order.
// The latency comes from two multiply-by-reciprocal divide-by-255 stages in series
// (multiply, divide, multiply, divide, select).
// Synchronous active-high reset clears the valid bits and sets the mode to multiply.
// busy is always low and the receiver cannot stall, so nothing ever waits.
`timescale 1ns / 1ps
`default_nettype none

module pixel_blend_unit_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire pbu_pkg::req_type req_data,
   output logic                  rsp_valid,
   output pbu_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [3:0]       csr_wr_data
);

   // floor(x / 255) by reciprocal multiply
   function automatic logic [8:0] div255(input logic [16:0] x);
      logic [34:0] prod;
      prod = 35'(x) * 35'(pbu_pkg::RECIP_255);
      return prod[pbu_pkg::RECIP_SHIFT + 8 : pbu_pkg::RECIP_SHIFT];
   endfunction

   // clamp at zero subtract
   function automatic logic [7:0] sub_clamp(input logic [7:0] p, input logic [7:0] q);
      return (p > q) ? 8'(p - q) : 8'd0;
   endfunction

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Mode register
   pbu_pkg::blend_mode_type mode_ff, mode_in;
   always_comb begin
      mode_in = mode_ff;
      if (csr_wr_en) begin
         mode_in = pbu_pkg::blend_mode_type'(csr_wr_data);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pbu_pkg::MODE_MUL;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Per-channel views of the input item: index 0 blue, 1 green, 2 red
   logic [2:0][7:0] a_in, b_in, c_in;
   always_comb begin
      a_in = {req_data.a_red, req_data.a_green, req_data.a_blue};
      b_in = {req_data.b_red, req_data.b_green, req_data.b_blue};
      c_in = {req_data.c_red, req_data.c_green, req_data.c_blue};
   end

   // Valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   // Payload carried along the pipe
   pbu_pkg::req_type        pix1_ff, pix2_ff, pix3_ff, pix4_ff;
   pbu_pkg::blend_mode_type mode1_ff, mode2_ff, mode3_ff, mode4_ff;
   logic [2:0][16:0]        x1_ff, x1_in, x2_ff, x2_in;
   logic [2:0][8:0]         q1_ff, q1_in, q1s3_ff, q1s4_ff, q2_ff, q2_in;

   // Stage 1: first product; overlay forms 2ab or 2(255-a)(255-b)+254 (ceil bias)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (mode_ff == pbu_pkg::MODE_OVERLAY) begin
            if (b_in[k] <= 8'd127) begin
               x1_in[k] = 17'({a_in[k], 1'b0}) * 17'(b_in[k]);
            end else begin
               x1_in[k] = 17'({8'(8'd255 - a_in[k]), 1'b0}) * 17'(8'(8'd255 - b_in[k]))
                          + 17'd254;
            end
         end else begin
            x1_in[k] = 17'(a_in[k]) * 17'(b_in[k]);
         end
      end
   end

   // Stage 2: first divide by 255
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q1_in[k] = div255(x1_ff[k]);
      end
   end

   // Stage 3: screen product (255-m)(255-c) with ceil bias
   logic [2:0][7:0] c2;
   always_comb begin
      c2 = {pix2_ff.c_red, pix2_ff.c_green, pix2_ff.c_blue};
      for (int k = 0; k < 3; k++) begin
         x2_in[k] = 17'(8'(8'd255 - q1_ff[k][7:0])) * 17'(8'(8'd255 - c2[k])) + 17'd254;
      end
   end

   // Stage 4: second divide by 255
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q2_in[k] = div255(x2_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      pix1_ff  <= req_data;
      mode1_ff <= mode_ff;
      x1_ff    <= x1_in;
      pix2_ff  <= pix1_ff;
      mode2_ff <= mode1_ff;
      q1_ff    <= q1_in;
      pix3_ff  <= pix2_ff;
      mode3_ff <= mode2_ff;
      q1s3_ff  <= q1_ff;
      x2_ff    <= x2_in;
      pix4_ff  <= pix3_ff;
      mode4_ff <= mode3_ff;
      q1s4_ff  <= q1s3_ff;
      q2_ff    <= q2_in;
   end

   // Stage 5: pick the result per mode
   logic [2:0][7:0] a4, b4, c4, r_in;
   logic [8:0]      green_sum;
   logic [9:0]      red_x4;
   pbu_pkg::rsp_type rsp_ff, rsp_in;
   always_comb begin
      a4 = {pix4_ff.a_red, pix4_ff.a_green, pix4_ff.a_blue};
      b4 = {pix4_ff.b_red, pix4_ff.b_green, pix4_ff.b_blue};
      c4 = {pix4_ff.c_red, pix4_ff.c_green, pix4_ff.c_blue};
      green_sum = 9'(pix4_ff.a_green) + 9'd200;
      red_x4    = {pix4_ff.a_red, 2'b00};
      r_in = '0;
      unique case (mode4_ff)
         pbu_pkg::MODE_MUL: begin
            for (int k = 0; k < 3; k++) r_in[k] = q1s4_ff[k][7:0];
         end
         pbu_pkg::MODE_SUB: begin
            for (int k = 0; k < 3; k++) r_in[k] = sub_clamp(a4[k], b4[k]);
         end
         pbu_pkg::MODE_MUL_SCREEN: begin
            for (int k = 0; k < 3; k++) r_in[k] = 8'(9'd255 - q2_ff[k]);
         end
         pbu_pkg::MODE_MUL_SUB: begin
            for (int k = 0; k < 3; k++) r_in[k] = sub_clamp(q1s4_ff[k][7:0], c4[k]);
         end
         pbu_pkg::MODE_OVERLAY: begin
            for (int k = 0; k < 3; k++) begin
               r_in[k] = (b4[k] <= 8'd127) ? q1s4_ff[k][7:0] : 8'(9'd255 - q1s4_ff[k]);
            end
         end
         pbu_pkg::MODE_GREEN_ADD: begin
            r_in    = a4;
            r_in[1] = green_sum[8] ? 8'd255 : green_sum[7:0];
         end
         pbu_pkg::MODE_BLUE0_RED4: begin
            r_in[0] = 8'd0;
            r_in[1] = a4[1];
            r_in[2] = (red_x4[9:8] != 2'b00) ? 8'd255 : red_x4[7:0];
         end
         pbu_pkg::MODE_COPY: begin
            r_in = a4;
         end
         pbu_pkg::MODE_MERGE: begin
            r_in[0] = c4[0];
            r_in[1] = b4[1];
            r_in[2] = a4[2];
         end
         default: begin
            r_in = '0;  // undefined modes give a black pixel
         end
      endcase
      rsp_in.out_blue  = r_in[0];
      rsp_in.out_green = r_in[1];
      rsp_in.out_red   = r_in[2];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Assertions
   pbu_pkg::blend_mode_type mode5_ff;
   pbu_pkg::req_type        pix5_ff;
   always_ff @(posedge clock) begin
      mode5_ff <= mode4_ff;
      pix5_ff  <= pix4_ff;
   end

   a_valid_follows_s4: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v4_ff))
      else $error("result strobe without an item in stage 4");

   a_s1_from_accept: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> $past(accept))
      else $error("stage 1 valid without an accepted item");

   a_copy_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode5_ff == pbu_pkg::MODE_COPY) |->
      (rsp_data.out_blue == pix5_ff.a_blue && rsp_data.out_green == pix5_ff.a_green
       && rsp_data.out_red == pix5_ff.a_red))
      else $error("copy mode result differs from first pixel");

   a_undef_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode5_ff > pbu_pkg::MODE_MERGE) |-> (rsp_data == '0))
      else $error("undefined mode gave a nonzero pixel");

endmodule

`default_nettype wire

// File: tb/pixel_blend_checker.sv
// Checker for the pixel blend unit: tracks the mode register, predicts each blended pixel
// and compares it with the result channel. Depends on pbu_pkg (mode codes, item structs).
`timescale 1ns / 1ps

module pixel_blend_checker
   import pbu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       busy,
   input  wire req_type    req_data,
   input  wire logic       rsp_valid,
   input  wire rsp_type    rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [3:0] csr_wr_data,
   output int              fail_count,
   output int              pending
);

   localparam int unsigned FULL_SCALE   = 255;
   localparam int unsigned OVERLAY_KNEE = 127;
   localparam int unsigned GREEN_LIFT   = 200;
   localparam int unsigned RED_GAIN     = 4;

   logic [3:0] mode_copy;
   rsp_type    pixel_q[$];

   // One channel of the arithmetic modes; 255 stands for 1.0
   function automatic logic [7:0] blend_channel_value(input logic [3:0] mode,
                                                      input logic [7:0] a,
                                                      input logic [7:0] b,
                                                      input logic [7:0] c);
      int unsigned av, bv, cv, prod;
      av   = 32'(a);
      bv   = 32'(b);
      cv   = 32'(c);
      prod = (av * bv) / FULL_SCALE;
      case (mode)
         MODE_MUL:        return 8'(prod);
         MODE_SUB:        return (av > bv) ? 8'(av - bv) : 8'd0;
         // screen rounds the inverted product up
         MODE_MUL_SCREEN: return 8'(FULL_SCALE
                                    - ((FULL_SCALE - prod) * (FULL_SCALE - cv)
                                       + FULL_SCALE - 1) / FULL_SCALE);
         MODE_MUL_SUB:    return (prod > cv) ? 8'(prod - cv) : 8'd0;
         MODE_OVERLAY: begin
            if (bv <= OVERLAY_KNEE)
               return 8'((2 * av * bv) / FULL_SCALE);
            return 8'(FULL_SCALE
                      - (2 * (FULL_SCALE - av) * (FULL_SCALE - bv) + FULL_SCALE - 1)
                      / FULL_SCALE);
         end
         default:         return 8'd0;
      endcase
   endfunction

   // Whole blended pixel for one item under the given mode
   function automatic rsp_type predict_blend(input logic [3:0] mode, input req_type px);
      rsp_type     res;
      int unsigned lifted, gained;
      res    = '0;
      lifted = 32'(px.a_green) + GREEN_LIFT;
      gained = 32'(px.a_red) * RED_GAIN;
      case (mode)
         MODE_MUL, MODE_SUB, MODE_MUL_SCREEN, MODE_MUL_SUB, MODE_OVERLAY: begin
            res.out_blue  = blend_channel_value(mode, px.a_blue, px.b_blue, px.c_blue);
            res.out_green = blend_channel_value(mode, px.a_green, px.b_green, px.c_green);
            res.out_red   = blend_channel_value(mode, px.a_red, px.b_red, px.c_red);
         end
         MODE_GREEN_ADD: begin
            res.out_blue  = px.a_blue;
            res.out_green = (lifted > FULL_SCALE) ? 8'(FULL_SCALE) : 8'(lifted);
            res.out_red   = px.a_red;
         end
         MODE_BLUE0_RED4: begin
            res.out_blue  = '0;
            res.out_green = px.a_green;
            res.out_red   = (gained > FULL_SCALE) ? 8'(FULL_SCALE) : 8'(gained);
         end
         MODE_COPY: begin
            res.out_blue  = px.a_blue;
            res.out_green = px.a_green;
            res.out_red   = px.a_red;
         end
         MODE_MERGE: begin
            res.out_blue  = px.c_blue;
            res.out_green = px.b_green;
            res.out_red   = px.a_red;
         end
         default: res = '0;  // undefined modes give black
      endcase
      return res;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      mode_copy  = MODE_MUL;
   end

   // Compare results, then record new items and register writes seen at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode_copy = MODE_MUL;
         pixel_q.delete();
      end else begin
         if (rsp_valid) begin
            if (pixel_q.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_data);
               fail_count++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_data.out_blue !== want.out_blue) begin
                  $error("out_blue: expected %0d, got %0d", want.out_blue, rsp_data.out_blue);
                  fail_count++;
               end
               if (rsp_data.out_green !== want.out_green) begin
                  $error("out_green: expected %0d, got %0d", want.out_green,
                         rsp_data.out_green);
                  fail_count++;
               end
               if (rsp_data.out_red !== want.out_red) begin
                  $error("out_red: expected %0d, got %0d", want.out_red, rsp_data.out_red);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            pixel_q.push_back(predict_blend(mode_copy, req_data));
         if (csr_wr_en)
            mode_copy = csr_wr_data;
      end
      pending = pixel_q.size();
   end

endmodule

// File: tb/pixel_blend_unit_top_tb.sv
// Testbench top for the pixel blend unit: clock, reset, stimulus and verdict.
// Depends on pbu_pkg, pixel_blend_unit_top and pixel_blend_checker.
`timescale 1ns / 1ps

module pixel_blend_unit_top_tb;
   import pbu_pkg::*;

   localparam logic [3:0] MODE_TOP       = 4'hF;
   localparam int         PIPE_LATENCY   = 5;
   localparam int         RANDOM_ITEMS   = 1630;
   localparam int         DRAIN_LIMIT    = 2000;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [3:0] csr_wr_data;
   int         fail_count;
   int         pending;

   int         burst_left;
   bit         gaps_on;

   pixel_blend_unit_top DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pixel_blend_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("pixel_blend_unit_top_tb: FAIL");
      $finish;
   end

   // Bytes lean toward the extremes and the overlay knee
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd127;
         3:       return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type random_pixels();
      req_type px;
      px.a_blue  = pick_byte();
      px.a_green = pick_byte();
      px.a_red   = pick_byte();
      px.b_blue  = pick_byte();
      px.b_green = pick_byte();
      px.b_red   = pick_byte();
      px.c_blue  = pick_byte();
      px.c_green = pick_byte();
      px.c_red   = pick_byte();
      return px;
   endfunction

   // Offer one item from a falling edge; return at the falling edge after it is taken
   task automatic send_item(input req_type px);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         start = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      start    = 1'b1;
      req_data = px;
      do @(posedge clock); while (busy);
      @(negedge clock);
      burst_left--;
   endtask

   // Change mode only once the pipeline is empty
   task automatic set_mode(input logic [3:0] mode);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (PIPE_LATENCY) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = mode;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   initial begin
      req_type    px;
      logic [3:0] mode;
      int         sent, phase, len, waited;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = MODE_MUL;
      burst_left  = 0;
      gaps_on     = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed: black and white pixels under every defined mode and two undefined ones
      for (int m = int'(MODE_MUL); m <= int'(MODE_MERGE) + 1; m++) begin
         set_mode(4'(m));
         send_item('0);
         send_item('1);
      end
      set_mode(MODE_TOP);
      send_item('0);
      send_item('1);

      // Directed: overlay on either side of its knee
      set_mode(MODE_OVERLAY);
      px = random_pixels();
      px.b_blue  = 8'd127;
      px.b_green = 8'd127;
      px.b_red   = 8'd127;
      send_item(px);
      px.b_blue  = 8'd128;
      px.b_green = 8'd128;
      px.b_red   = 8'd128;
      send_item(px);

      // Random phases, each under one mode; the first three take the extreme settings
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 0)
            mode = MODE_MUL;
         else if (phase == 1)
            mode = MODE_MERGE;
         else if (phase == 2)
            mode = MODE_TOP;
         else if ($urandom_range(0, 3) == 0)
            mode = 4'($urandom_range(MODE_MERGE + 1, MODE_TOP));
         else
            mode = 4'($urandom_range(MODE_MUL, MODE_MERGE));
         set_mode(mode);
         gaps_on    = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         len        = $urandom_range(10, 120);
         repeat (len) begin
            send_item(random_pixels());
            sent++;
         end
         phase++;
      end
      start = 1'b0;

      // Drain, then give the pipeline a little longer to show stray results
      waited = 0;
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (PIPE_LATENCY * 2) @(negedge clock);
      if (pending != 0)
         $error("%0d pixels never came out", pending);

      if (fail_count == 0 && pending == 0)
         $display("pixel_blend_unit_top_tb: PASS");
      else
         $display("pixel_blend_unit_top_tb: FAIL");
      $finish;
   end

endmodule

// File: sim.f
design/pbu_pkg.sv
design/pixel_blend_unit_top.sv
tb/pixel_blend_checker.sv
tb/pixel_blend_unit_top_tb.sv
